/* rtl/chip8_core_subset_defines.svh */
// Assertion macros used by the core's top-level RTL file.
// Each macro expects signals named clock and reset in the including module.
`ifndef CHIP8_CORE_SUBSET_DEFINES_SVH
`define CHIP8_CORE_SUBSET_DEFINES_SVH

// Implication checked in the same cycle.
`define C8CS_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Implication checked in the next cycle.
`define C8CS_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/c8cs_pkg.sv */
// Shared constants and types of the reduced CHIP-8 core.
// No dependencies; imported by the top level.
`default_nettype none

package c8cs_pkg;

   localparam int unsigned MEMORY_BYTES_DEFAULT = 4096;
   localparam int unsigned SCREEN_ROWS          = 32;
   localparam int unsigned SCREEN_COLS          = 64;
   localparam int unsigned REG_COUNT            = 16;
   localparam int unsigned ROW_AW               = $clog2(SCREEN_ROWS);
   localparam int unsigned COL_AW               = $clog2(SCREEN_COLS);
   localparam int unsigned REG_AW               = $clog2(REG_COUNT);

   localparam logic [12:0] PC_RESET = 13'd512;

   typedef logic [1:0] kind_type;
   typedef logic [1:0] status_type;
   typedef logic [3:0] opcode_type;

   localparam kind_type KIND_EXEC   = 2'd0;
   localparam kind_type KIND_LOAD   = 2'd1;
   localparam kind_type KIND_SCREEN = 2'd2;
   localparam kind_type KIND_REG    = 2'd3;

   localparam status_type STATUS_OK    = 2'd0;
   localparam status_type STATUS_RANGE = 2'd1;
   localparam status_type STATUS_UNDEF = 2'd2;

   localparam opcode_type OP_CLS   = 4'h0;
   localparam opcode_type OP_JUMP  = 4'h1;
   localparam opcode_type OP_SET   = 4'h6;
   localparam opcode_type OP_ADD   = 4'h7;
   localparam opcode_type OP_INDEX = 4'hA;
   localparam opcode_type OP_DRAW  = 4'hD;

   localparam logic [REG_AW-1:0] VF_INDEX = 4'hF;

endpackage

`default_nettype wire

/* rtl/c8cs_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`default_nettype none

module c8cs_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 16,
   localparam int unsigned AW   = $clog2(DEPTH)
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* rtl/chip8_core_subset.sv */
// Reduced CHIP-8 core: top level with the control sequencer; uses c8cs_pkg, c8cs_ram and
// the assertion macros. One request is taken at a time (start while busy is low) and
// answered by exactly one result, shown for one cycle under rsp_strobe; the receiver
// cannot stall, so it must capture the result in that cycle. A new request may be
// issued in the same cycle that the previous result is shown. A load, or an execute whose
// program counter is out of range, answers straight from idle; a screen or register read
// once its data returns; other executes once both opcode bytes return, add after VX is
// read, draw DXYN after VX and VY are read, VF cleared, the index folded into memory
// size and every sprite row redrawn. Throughput is set by the single read port of program
// memory and of the screen memory: each sprite row takes one screen read and one screen
// write. Program memory is not cleared by reset; the screen and data registers read as
// zero until written, tracked by per-entry valid bits, so no clearing pass is needed.
`default_nettype none
`include "chip8_core_subset_defines.svh"

module chip8_core_subset
   import c8cs_pkg::*;
#(
   parameter int unsigned MEMORY_BYTES = MEMORY_BYTES_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [1:0]  req_kind,
   input  wire logic [11:0] req_location,
   input  wire logic [7:0]  req_load_data,
   output logic             rsp_strobe,
   output logic [1:0]       rsp_status,
   output logic [12:0]      rsp_pc_value,
   output logic [11:0]      rsp_index_value,
   output logic [7:0]       rsp_reg_value,
   output logic [63:0]      rsp_screen_row
);

   localparam int unsigned AW = $clog2(MEMORY_BYTES);

   // sequencer states
   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_RDS  = 4'd1;   // screen row read data returns
   localparam logic [3:0] S_RDR  = 4'd2;   // register read data returns
   localparam logic [3:0] S_F1   = 4'd3;   // high opcode byte returns
   localparam logic [3:0] S_EXEC = 4'd4;   // low byte returns, decode
   localparam logic [3:0] S_ADD  = 4'd5;   // VX returns, write sum
   localparam logic [3:0] S_DRX  = 4'd6;   // VX returns, read VY
   localparam logic [3:0] S_DRY  = 4'd7;   // VY returns, clear VF
   localparam logic [3:0] S_DMOD = 4'd8;   // fold index into memory size
   localparam logic [3:0] S_DROW = 4'd9;   // sprite byte returns, read screen row
   localparam logic [3:0] S_DWR  = 4'd10;  // XOR row and write back

   // control and architectural state
   logic [3:0]             state_ff, state_in;
   logic [12:0]            pc_ff, pc_in;
   logic [11:0]            index_ff, index_in;
   logic [REG_COUNT-1:0]   reg_valid_ff, reg_valid_in;
   logic [SCREEN_ROWS-1:0] scr_valid_ff, scr_valid_in;
   logic                   rsp_strobe_ff, rsp_strobe_in;

   // working registers
   logic [7:0]        opa_ff, opa_in;
   logic [7:0]        opb_ff, opb_in;
   logic [7:0]        spr_ff, spr_in;
   logic [11:0]       addr_ff, addr_in;
   logic [3:0]        cnt_ff, cnt_in;
   logic [ROW_AW-1:0] row_ff, row_in;
   logic [COL_AW-1:0] sx_ff, sx_in;
   logic              hit_ff, hit_in;
   logic [REG_AW-1:0] ridx_ff;
   status_type        rsp_status_ff, rsp_status_in;
   logic [7:0]        rsp_reg_ff, rsp_reg_in;
   logic [63:0]       rsp_row_ff, rsp_row_in;

   // memory ports
   logic              mem_wr_en;
   logic [AW-1:0]     mem_rd_addr;
   logic [7:0]        mem_rd_data;
   logic              scr_wr_en;
   logic [ROW_AW-1:0] scr_rd_addr;
   logic [63:0]       scr_rd_data;
   logic [63:0]       scr_wr_data;
   logic              reg_wr_en;
   logic [REG_AW-1:0] reg_wr_addr;
   logic [7:0]        reg_wr_data;
   logic [REG_AW-1:0] reg_rd_addr;
   logic [7:0]        reg_rd_data;

   // derived values
   logic [12:0]  pc_plus1;
   logic         pc_out_of_range;
   logic         load_in_range;
   logic [7:0]   reg_val;
   logic [63:0]  scr_val;
   logic [127:0] spr_wide;
   logic [63:0]  spr_mask;
   logic         collide;
   logic [11:0]  addr_next;

   assign pc_plus1        = pc_ff + 13'd1;
   assign pc_out_of_range = ({1'b0, pc_plus1} >= 14'(MEMORY_BYTES));
   assign load_in_range   = ({1'b0, req_location} < 13'(MEMORY_BYTES));

   // unwritten registers and rows read as zero
   assign reg_val = reg_valid_ff[ridx_ff] ? reg_rd_data : 8'd0;
   assign scr_val = scr_valid_ff[row_ff]  ? scr_rd_data : 64'd0;

   // sprite byte placed at column sx, wrapping at the right edge (bit 63 is column 0)
   assign spr_wide = {spr_ff, 56'd0, spr_ff, 56'd0} >> sx_ff;
   assign spr_mask = spr_wide[63:0];
   assign collide  = |(scr_val & spr_mask);
   assign scr_wr_data = scr_val ^ spr_mask;

   assign addr_next = (addr_ff == 12'(MEMORY_BYTES - 1)) ? 12'd0 : addr_ff + 12'd1;

   always_comb begin
      state_in      = state_ff;
      pc_in         = pc_ff;
      index_in      = index_ff;
      reg_valid_in  = reg_valid_ff;
      scr_valid_in  = scr_valid_ff;
      rsp_strobe_in = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_reg_in    = rsp_reg_ff;
      rsp_row_in    = rsp_row_ff;
      opa_in        = opa_ff;
      opb_in        = opb_ff;
      spr_in        = spr_ff;
      addr_in       = addr_ff;
      cnt_in        = cnt_ff;
      row_in        = row_ff;
      sx_in         = sx_ff;
      hit_in        = hit_ff;
      mem_wr_en     = 1'b0;
      mem_rd_addr   = addr_ff[AW-1:0];
      scr_wr_en     = 1'b0;
      scr_rd_addr   = row_ff;
      reg_wr_en     = 1'b0;
      reg_wr_addr   = opa_ff[REG_AW-1:0];
      reg_wr_data   = opb_ff;
      reg_rd_addr   = opa_ff[REG_AW-1:0];

      unique case (state_ff)
         S_IDLE: begin
            mem_rd_addr = pc_ff[AW-1:0];
            scr_rd_addr = req_location[ROW_AW-1:0];
            reg_rd_addr = req_location[REG_AW-1:0];
            if (start) begin
               rsp_status_in = STATUS_OK;
               rsp_reg_in    = 8'd0;
               rsp_row_in    = 64'd0;
               unique case (req_kind)
                  KIND_EXEC: begin
                     if (pc_out_of_range) begin
                        rsp_status_in = STATUS_RANGE;
                        rsp_strobe_in = 1'b1;
                     end else begin
                        state_in = S_F1;
                     end
                  end
                  KIND_LOAD: begin
                     mem_wr_en     = load_in_range;
                     rsp_strobe_in = 1'b1;
                  end
                  KIND_SCREEN: begin
                     row_in   = req_location[ROW_AW-1:0];
                     state_in = S_RDS;
                  end
                  KIND_REG: begin
                     state_in = S_RDR;
                  end
                  default: state_in = S_IDLE;
               endcase
            end
         end
         S_RDS: begin
            rsp_row_in    = scr_val;
            rsp_strobe_in = 1'b1;
            state_in      = S_IDLE;
         end
         S_RDR: begin
            rsp_reg_in    = reg_val;
            rsp_strobe_in = 1'b1;
            state_in      = S_IDLE;
         end
         S_F1: begin
            mem_rd_addr = pc_plus1[AW-1:0];
            opa_in      = mem_rd_data;
            state_in    = S_EXEC;
         end
         S_EXEC: begin
            opb_in        = mem_rd_data;
            pc_in         = pc_ff + 13'd2;
            rsp_strobe_in = 1'b1;
            state_in      = S_IDLE;
            unique case (opa_ff[7:4])
               OP_CLS:   scr_valid_in = '0;
               OP_JUMP:  pc_in = {1'b0, opa_ff[3:0], mem_rd_data};
               OP_SET: begin
                  reg_wr_en   = 1'b1;
                  reg_wr_data = mem_rd_data;
                  reg_valid_in[opa_ff[REG_AW-1:0]] = 1'b1;
               end
               OP_ADD: begin
                  rsp_strobe_in = 1'b0;
                  state_in      = S_ADD;
               end
               OP_INDEX: index_in = {opa_ff[3:0], mem_rd_data};
               OP_DRAW: begin
                  rsp_strobe_in = 1'b0;
                  state_in      = S_DRX;
               end
               default:  rsp_status_in = STATUS_UNDEF;
            endcase
         end
         S_ADD: begin
            reg_wr_en     = 1'b1;
            reg_wr_data   = reg_val + opb_ff;
            reg_valid_in[opa_ff[REG_AW-1:0]] = 1'b1;
            rsp_strobe_in = 1'b1;
            state_in      = S_IDLE;
         end
         S_DRX: begin
            sx_in       = reg_val[COL_AW-1:0];
            reg_rd_addr = opb_ff[7:4];
            state_in    = S_DRY;
         end
         S_DRY: begin
            // start point is taken before VF is cleared
            row_in      = reg_val[ROW_AW-1:0];
            reg_wr_en   = 1'b1;
            reg_wr_addr = VF_INDEX;
            reg_wr_data = 8'd0;
            reg_valid_in[VF_INDEX] = 1'b1;
            hit_in      = 1'b0;
            addr_in     = index_ff;
            cnt_in      = opb_ff[3:0];
            state_in    = S_DMOD;
         end
         S_DMOD: begin
            if ({1'b0, addr_ff} >= 13'(MEMORY_BYTES)) begin
               addr_in = addr_ff - 12'(MEMORY_BYTES);
            end else if (cnt_ff == 4'd0) begin
               rsp_strobe_in = 1'b1;
               state_in      = S_IDLE;
            end else begin
               state_in = S_DROW;
            end
         end
         S_DROW: begin
            spr_in   = mem_rd_data;
            addr_in  = addr_next;
            state_in = S_DWR;
         end
         S_DWR: begin
            scr_wr_en            = 1'b1;
            scr_valid_in[row_ff] = 1'b1;
            hit_in               = hit_ff | collide;
            cnt_in               = cnt_ff - 4'd1;
            row_in               = row_ff + ROW_AW'(1);
            if (cnt_ff == 4'd1) begin
               reg_wr_en     = 1'b1;
               reg_wr_addr   = VF_INDEX;
               reg_wr_data   = {7'd0, hit_ff | collide};
               rsp_strobe_in = 1'b1;
               state_in      = S_IDLE;
            end else begin
               state_in = S_DROW;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         pc_ff         <= PC_RESET;
         index_ff      <= 12'd0;
         reg_valid_ff  <= '0;
         scr_valid_ff  <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         pc_ff         <= pc_in;
         index_ff      <= index_in;
         reg_valid_ff  <= reg_valid_in;
         scr_valid_ff  <= scr_valid_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      opa_ff        <= opa_in;
      opb_ff        <= opb_in;
      spr_ff        <= spr_in;
      addr_ff       <= addr_in;
      cnt_ff        <= cnt_in;
      row_ff        <= row_in;
      sx_ff         <= sx_in;
      hit_ff        <= hit_in;
      ridx_ff       <= reg_rd_addr;
      rsp_status_ff <= rsp_status_in;
      rsp_reg_ff    <= rsp_reg_in;
      rsp_row_ff    <= rsp_row_in;
   end

   // program memory: loads write, fetch and sprite reads share the read port
   c8cs_ram #(
      .WIDTH (8),
      .DEPTH (MEMORY_BYTES)
   ) u_prog_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (req_location[AW-1:0]),
      .wr_data (req_load_data),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // screen: one 64-bit word per row
   c8cs_ram #(
      .WIDTH (SCREEN_COLS),
      .DEPTH (SCREEN_ROWS)
   ) u_screen_mem (
      .clock   (clock),
      .wr_en   (scr_wr_en),
      .wr_addr (row_ff),
      .wr_data (scr_wr_data),
      .rd_addr (scr_rd_addr),
      .rd_data (scr_rd_data)
   );

   // data registers V0..VF
   c8cs_ram #(
      .WIDTH (8),
      .DEPTH (REG_COUNT)
   ) u_reg_mem (
      .clock   (clock),
      .wr_en   (reg_wr_en),
      .wr_addr (reg_wr_addr),
      .wr_data (reg_wr_data),
      .rd_addr (reg_rd_addr),
      .rd_data (reg_rd_data)
   );

   assign busy            = (state_ff != S_IDLE);
   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_pc_value    = pc_ff;
   assign rsp_index_value = index_ff;
   assign rsp_reg_value   = rsp_reg_ff;
   assign rsp_screen_row  = rsp_row_ff;

   // a taken request either starts work or answers at once
   `C8CS_ASSERT_NEXT(a_req_progress, start && !busy, busy || rsp_strobe, "request dropped")
   // results appear only once the sequencer is back in idle
   `C8CS_ASSERT_SAME(a_rsp_idle, rsp_strobe, !busy, "result shown while busy")
   // an out-of-range status leaves a counter that still cannot fetch
   `C8CS_ASSERT_SAME(a_range_pc, rsp_strobe && (rsp_status == STATUS_RANGE),
      ({1'b0, rsp_pc_value} + 14'd1) >= 14'(MEMORY_BYTES), "range status with fetchable pc")
   // sprite fetches stay inside program memory
   `C8CS_ASSERT_SAME(a_sprite_addr, state_ff == S_DROW,
      {1'b0, addr_ff} < 13'(MEMORY_BYTES), "sprite address not folded")

endmodule

`default_nettype wire

/* dv/tb_chip8_core_subset.sv */
// Self-checking bench for chip8_core_subset: a short directed table, then random
// instruction streams; each response is compared with an in-bench model of the core or,
// for typed rows, a hand-written answer. Depends on c8cs_pkg and the core's RTL only.

module tb_chip8_core_subset;
   timeunit 1ns;
   timeprecision 1ps;

   import c8cs_pkg::*;

   localparam int unsigned MEM_BYTES    = MEMORY_BYTES_DEFAULT;
   localparam int unsigned HALF_PERIOD  = 5;
   localparam int unsigned RUN_LIMIT_NS = 4_000_000;
   // Highest pc at which a non-jump may run and still leave a legal fetch behind it.
   localparam int unsigned PC_SAFE      = MEM_BYTES - 4;
   // Highest legal jump target for the random streams (fetch of pc and pc+1 in range).
   localparam int unsigned JUMP_MAX     = MEM_BYTES - 2;
   // Request counts at which the sender's idle rate changes, and where random stops.
   localparam int unsigned FIRST_SWAP   = 370;
   localparam int unsigned SECOND_SWAP  = 700;
   localparam int unsigned RANDOM_END   = 1040;
   localparam int unsigned PLAN_ROWS    = 27;

   // One response as the core presents it.
   typedef struct packed {
      status_type  status;
      logic [12:0] pc;
      logic [11:0] idx;
      logic [7:0]  vreg;
      logic [63:0] row;
   } answer_t;

   // One row of the directed table; typed rows carry a hand-written answer.
   typedef struct packed {
      kind_type    kind;
      logic [11:0] loc;
      logic [7:0]  data;
      bit          typed;
      answer_t     ans;
   } plan_row_t;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   kind_type    req_kind = KIND_EXEC;
   logic [11:0] req_location = '0;
   logic [7:0]  req_load_data = '0;
   logic        busy;
   logic        rsp_strobe;
   status_type  rsp_status;
   logic [12:0] rsp_pc_value;
   logic [11:0] rsp_index_value;
   logic [7:0]  rsp_reg_value;
   logic [63:0] rsp_screen_row;

   // Model of the core's architectural state.
   logic [7:0]  mem_model [MEM_BYTES];
   bit          mem_loaded [MEM_BYTES];   // bytes ever written; unwritten ones are never read
   logic [7:0]  v_model [REG_COUNT];
   logic [63:0] frame_model [SCREEN_ROWS];
   logic [12:0] pc_model;
   logic [11:0] i_model;

   answer_t     pending_answers [$];
   plan_row_t   plan [PLAN_ROWS];
   int unsigned sent_count = 0;
   int unsigned mismatch_count = 0;
   int unsigned sender_idle_pct = 14;

   always #(HALF_PERIOD) clock = ~clock;

   chip8_core_subset #(
      .MEMORY_BYTES (MEM_BYTES)
   ) i_dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_kind        (req_kind),
      .req_location    (req_location),
      .req_load_data   (req_load_data),
      .rsp_strobe      (rsp_strobe),
      .rsp_status      (rsp_status),
      .rsp_pc_value    (rsp_pc_value),
      .rsp_index_value (rsp_index_value),
      .rsp_reg_value   (rsp_reg_value),
      .rsp_screen_row  (rsp_screen_row)
   );

   // Applies one accepted request to the model and returns the response it must produce.
   function automatic answer_t step_core_model(kind_type k, logic [11:0] loc, logic [7:0] d);
      answer_t     ans;
      logic [7:0]  hi, lo, sprite;
      logic [3:0]  x, y;
      int unsigned at, sx, sy, r, c, row, col;
      bit          hit;
      ans = '0;
      ans.status = STATUS_OK;
      case (k)
         KIND_EXEC: begin
            at = 32'(pc_model);
            // Fetch past the end of memory: report and leave everything alone.
            if (at + 1 >= MEM_BYTES) begin
               ans.status = STATUS_RANGE;
            end else begin
               hi = mem_model[at];
               lo = mem_model[at + 1];
               pc_model = pc_model + 13'd2;
               x = hi[3:0];
               y = lo[7:4];
               case (hi[7:4])
                  OP_CLS: begin
                     for (row = 0; row < SCREEN_ROWS; row++) frame_model[row] = '0;
                  end
                  OP_JUMP: pc_model = {1'b0, x, lo};
                  OP_SET: v_model[x] = lo;
                  OP_ADD: v_model[x] = v_model[x] + lo;   // 8-bit wrap, VF untouched
                  OP_INDEX: i_model = {x, lo};
                  OP_DRAW: begin
                     // Origin is taken before VF is touched; both axes wrap.
                     sx = 32'(v_model[x]);
                     sy = 32'(v_model[y]);
                     hit = 1'b0;
                     for (r = 0; r < 32'(lo[3:0]); r++) begin
                        sprite = mem_model[(32'(i_model) + r) % MEM_BYTES];
                        row = (sy + r) % SCREEN_ROWS;
                        for (c = 0; c < 8; c++) begin
                           if (sprite[7 - c]) begin
                              col = SCREEN_COLS - 1 - ((sx + c) % SCREEN_COLS);
                              if (frame_model[row][col]) hit = 1'b1;
                              frame_model[row][col] = ~frame_model[row][col];
                           end
                        end
                     end
                     v_model[VF_INDEX] = {7'd0, hit};
                  end
                  default: ans.status = STATUS_UNDEF;   // pc already moved on by 2
               endcase
            end
         end
         KIND_LOAD: begin
            if (32'(loc) < MEM_BYTES) begin
               mem_model[loc] = d;
               mem_loaded[loc] = 1'b1;
            end
         end
         KIND_SCREEN: ans.row = frame_model[loc[ROW_AW-1:0]];
         default: ans.vreg = v_model[loc[REG_AW-1:0]];
      endcase
      ans.pc = pc_model;
      ans.idx = i_model;
      return ans;
   endfunction

   function automatic plan_row_t free_row(kind_type k, logic [11:0] loc, logic [7:0] d);
      plan_row_t rw;
      rw = '0;
      rw.kind = k;
      rw.loc = loc;
      rw.data = d;
      return rw;
   endfunction

   // Typed rows only ever expect a zero register value and an empty row.
   function automatic plan_row_t typed_row(kind_type k, logic [11:0] loc, logic [7:0] d,
                                           status_type st, logic [12:0] pc, logic [11:0] idx);
      plan_row_t rw;
      rw = free_row(k, loc, d);
      rw.typed = 1'b1;
      rw.ans.status = st;
      rw.ans.pc = pc;
      rw.ans.idx = idx;
      return rw;
   endfunction

   // True when the opcode already at pc can run in place: both bytes and any sprite
   // bytes have been written, and pc stays where a later fetch is still legal.
   function automatic bit fetch_safe();
      int unsigned at, r;
      logic [7:0]  hi, lo;
      at = 32'(pc_model);
      if (at + 1 >= MEM_BYTES) return 1'b0;
      if (!mem_loaded[at] || !mem_loaded[at + 1]) return 1'b0;
      hi = mem_model[at];
      lo = mem_model[at + 1];
      if (hi[7:4] == OP_JUMP) return 32'({hi[3:0], lo}) <= JUMP_MAX;
      if (at > PC_SAFE) return 1'b0;
      if (hi[7:4] == OP_DRAW) begin
         for (r = 0; r < 32'(lo[3:0]); r++) begin
            if (!mem_loaded[(32'(i_model) + r) % MEM_BYTES]) return 1'b0;
         end
      end
      return 1'b1;
   endfunction

   function automatic logic [15:0] random_opcode();
      int unsigned pick;
      logic [3:0]  x, y, n, hi_op;
      logic [7:0]  nn;
      logic [11:0] target;
      pick = $urandom_range(99);
      x = 4'($urandom);
      y = 4'($urandom);
      nn = 8'($urandom);
      // Half the jumps land in a small region so code gets re-run in place.
      if ($urandom_range(1) == 1) target = 12'($urandom_range(1023, 512));
      else target = 12'($urandom_range(JUMP_MAX));
      // Mostly short sprites; now and then any height up to fifteen.
      if ($urandom_range(7) == 0) n = 4'($urandom);
      else n = 4'($urandom_range(4));
      if (32'(pc_model) > PC_SAFE || (pick >= 75 && pick < 82)) return {OP_JUMP, target};
      if (pick < 18) return {OP_SET, x, nn};
      if (pick < 33) return {OP_ADD, x, nn};
      if (pick < 45) return {OP_INDEX, 12'($urandom)};
      if (pick < 75) return {OP_DRAW, x, y, n};
      if (pick < 87) return {OP_CLS, x, nn};
      do begin
         hi_op = 4'($urandom);
      end while (hi_op == OP_CLS || hi_op == OP_JUMP || hi_op == OP_SET ||
                 hi_op == OP_ADD || hi_op == OP_INDEX || hi_op == OP_DRAW);
      return {hi_op, x, nn};
   endfunction

   // Presents one request after random idle cycles and holds it until the core takes it.
   // Called aligned to a rising edge; returns at the edge that accepted the request.
   task automatic send_request(input kind_type k, input logic [11:0] loc, input logic [7:0] d,
                               input bit typed = 1'b0, input answer_t typed_ans = '0);
      answer_t predicted;
      while ($urandom_range(99) < sender_idle_pct) begin
         start <= 1'b0;
         req_kind <= kind_type'($urandom);
         req_location <= 12'($urandom);
         req_load_data <= 8'($urandom);
         @(posedge clock);
      end
      start <= 1'b1;
      req_kind <= k;
      req_location <= loc;
      req_load_data <= d;
      @(posedge clock);
      while (busy) @(posedge clock);
      predicted = step_core_model(k, loc, d);
      pending_answers.push_back(typed ? typed_ans : predicted);
      sent_count++;
   endtask

   // Writes the opcode at pc (plus any sprite bytes the draw needs) and runs it.
   task automatic run_instruction(input logic [15:0] op);
      int unsigned r, at;
      if (op[15:12] == OP_DRAW) begin
         for (r = 0; r < 32'(op[3:0]); r++) begin
            at = (32'(i_model) + r) % MEM_BYTES;
            if (!mem_loaded[at] || $urandom_range(2) == 0)
               send_request(KIND_LOAD, 12'(at), 8'($urandom));
         end
      end
      send_request(KIND_LOAD, pc_model[11:0], op[15:8]);
      send_request(KIND_LOAD, 12'(pc_model + 13'd1), op[7:0]);
      send_request(KIND_EXEC, 12'($urandom), 8'($urandom));
   endtask

   // Sender holds off until every outstanding request has been answered.
   task automatic wait_for_answers();
      start <= 1'b0;
      while (pending_answers.size() != 0) @(posedge clock);
   endtask

   function automatic void compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
         $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want, got);
         mismatch_count++;
      end
   endfunction

   // Response checker: the receiver never stalls, so every strobe is a response.
   always @(posedge clock) begin : response_check
      answer_t want;
      if (!reset && rsp_strobe) begin
         if (pending_answers.size() == 0) begin
            $display("%0t ns: response mismatch, expected none, actual status %h pc %h",
                     $time, rsp_status, rsp_pc_value);
            mismatch_count++;
         end else begin
            want = pending_answers.pop_front();
            compare_field("status", 64'(want.status), 64'(rsp_status));
            compare_field("pc_value", 64'(want.pc), 64'(rsp_pc_value));
            compare_field("index_value", 64'(want.idx), 64'(rsp_index_value));
            compare_field("reg_value", 64'(want.vreg), 64'(rsp_reg_value));
            compare_field("screen_row", want.row, rsp_screen_row);
         end
      end
   end

   initial begin : run_limit
      #(RUN_LIMIT_NS);
      $display("chip8_core_subset regression: fail");
      $finish;
   end

   initial begin : stimulus
      int unsigned pick, k;
      // Model state after reset; memory stays unknown until loaded.
      for (k = 0; k < REG_COUNT; k++) v_model[k] = '0;
      for (k = 0; k < SCREEN_ROWS; k++) frame_model[k] = '0;
      pc_model = PC_RESET;
      i_model = '0;

      // Directed program at 0x200: V0 = BF, V0 += 80 (wraps to 3F), I = FFF,
      // draw 2 rows at (63,63) so both axes wrap and the sprite fetch wraps FFF -> 000,
      // jump back and redraw (collision, VF = 1), undefined opcode, clear screen.
      plan[0]  = typed_row(KIND_REG, 12'h000, 8'h00, STATUS_OK, PC_RESET, 12'h000);
      plan[1]  = typed_row(KIND_SCREEN, 12'hFFF, 8'hFF, STATUS_OK, PC_RESET, 12'h000);
      plan[2]  = typed_row(KIND_LOAD, 12'hFFF, 8'hC3, STATUS_OK, PC_RESET, 12'h000);
      plan[3]  = free_row(KIND_LOAD, 12'h000, 8'h81);
      plan[4]  = free_row(KIND_LOAD, 12'h200, 8'h60);
      plan[5]  = free_row(KIND_LOAD, 12'h201, 8'hBF);
      plan[6]  = free_row(KIND_EXEC, 12'hFFF, 8'hFF);
      plan[7]  = free_row(KIND_LOAD, 12'h202, 8'h70);
      plan[8]  = free_row(KIND_LOAD, 12'h203, 8'h80);
      plan[9]  = free_row(KIND_EXEC, 12'h000, 8'h00);
      plan[10] = free_row(KIND_LOAD, 12'h204, 8'hAF);
      plan[11] = free_row(KIND_LOAD, 12'h205, 8'hFF);
      plan[12] = typed_row(KIND_EXEC, 12'h000, 8'h00, STATUS_OK, 13'h206, 12'hFFF);
      plan[13] = free_row(KIND_LOAD, 12'h206, 8'hD0);
      plan[14] = free_row(KIND_LOAD, 12'h207, 8'h02);
      plan[15] = free_row(KIND_EXEC, 12'hFFF, 8'hFF);
      plan[16] = free_row(KIND_SCREEN, 12'h03F, 8'h00);   // row 31 through high bits
      plan[17] = free_row(KIND_LOAD, 12'h208, 8'h12);
      plan[18] = free_row(KIND_LOAD, 12'h209, 8'h06);
      plan[19] = typed_row(KIND_EXEC, 12'h000, 8'h00, STATUS_OK, 13'h206, 12'hFFF);
      plan[20] = free_row(KIND_EXEC, 12'hFFF, 8'hFF);
      plan[21] = free_row(KIND_REG, 12'hFFF, 8'h00);      // VF through high bits
      plan[22] = free_row(KIND_LOAD, 12'h208, 8'hF0);
      plan[23] = typed_row(KIND_EXEC, 12'h000, 8'h00, STATUS_UNDEF, 13'h20A, 12'hFFF);
      plan[24] = free_row(KIND_LOAD, 12'h20A, 8'h00);
      plan[25] = free_row(KIND_LOAD, 12'h20B, 8'hE0);
      plan[26] = free_row(KIND_EXEC, 12'hFFF, 8'hFF);

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      for (k = 0; k < PLAN_ROWS; k++)
         send_request(plan[k].kind, plan[k].loc, plan[k].data, plan[k].typed, plan[k].ans);

      // Random part: mostly complete instructions with random content, plus reads,
      // in-place re-execution and stray loads. Sender idles 14%, then 77%, then never;
      // at each change the sender drains all outstanding responses first.
      while (sent_count < RANDOM_END) begin
         if (sender_idle_pct == 14 && sent_count >= FIRST_SWAP) begin
            wait_for_answers();
            sender_idle_pct = 77;
         end else if (sender_idle_pct == 77 && sent_count >= SECOND_SWAP) begin
            wait_for_answers();
            sender_idle_pct = 0;
         end
         pick = $urandom_range(99);
         if (pick < 62) run_instruction(random_opcode());
         else if (pick < 72 && fetch_safe())
            send_request(KIND_EXEC, 12'($urandom), 8'($urandom));
         else if (pick < 84) send_request(KIND_SCREEN, 12'($urandom), 8'($urandom));
         else if (pick < 93) send_request(KIND_REG, 12'($urandom), 8'($urandom));
         else send_request(KIND_LOAD, 12'($urandom), 8'($urandom));
      end

      // Out-of-range fetch is terminal, so it closes the run: jump to FFE, which
      // jumps to FFF, where the fetch of pc+1 falls off the end of memory.
      wait_for_answers();
      run_instruction({OP_JUMP, 12'hFFE});
      run_instruction({OP_JUMP, 12'hFFF});
      send_request(KIND_EXEC, 12'($urandom), 8'($urandom));
      send_request(KIND_EXEC, 12'($urandom), 8'($urandom));

      wait_for_answers();
      // Longest response is a 15-row draw; any strobe after this wait is spurious.
      repeat (64) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("chip8_core_subset regression: pass");
      end else begin
         $display("chip8_core_subset regression: fail");
      end
      $finish;
   end

endmodule

/* files.f */
+incdir+rtl
rtl/c8cs_pkg.sv
rtl/c8cs_ram.sv
rtl/chip8_core_subset.sv
dv/tb_chip8_core_subset.sv
